// ===== sv/utf16_to_utf8_transcoder_unit_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define U2U_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u2u assertion failed");
`define U2U_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u2u assertion failed");
`else
`define U2U_ASSERT_IMP(name, clk, rst, ante, cons)
`define U2U_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/u2u_pkg.sv =====
`default_nettype none
package u2u_pkg;

  localparam logic [5:0] HIGH_SURR_TAG = 6'h36;
  localparam logic [5:0] LOW_SURR_TAG  = 6'h37;
  localparam logic [10:0] PLANE_OFFSET = 11'h040;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            done;
    logic            err;
  } job_t;

  typedef struct packed {
    logic pending;
    logic discarding;
  } front_status_t;

  function automatic job_t error_job();
    job_t j;
    j.bytes    = '0;
    j.last_idx = 2'd0;
    j.done     = 1'b1;
    j.err      = 1'b1;
    error_job  = j;
  endfunction

  function automatic job_t scalar_job(input logic [20:0] v, input logic end_flag);
    job_t j;
    j.bytes = '0;
    j.done  = end_flag;
    j.err   = 1'b0;
    if (v[20:7] == '0) begin
      j.bytes[0] = v[7:0];
      j.last_idx = 2'd0;
    end else if (v[20:11] == '0) begin
      j.bytes[0] = {3'b110, v[10:6]};
      j.bytes[1] = {2'b10, v[5:0]};
      j.last_idx = 2'd1;
    end else if (v[20:16] == '0) begin
      j.bytes[0] = {4'b1110, v[15:12]};
      j.bytes[1] = {2'b10, v[11:6]};
      j.bytes[2] = {2'b10, v[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, v[20:18]};
      j.bytes[1] = {2'b10, v[17:12]};
      j.bytes[2] = {2'b10, v[11:6]};
      j.bytes[3] = {2'b10, v[5:0]};
      j.last_idx = 2'd3;
    end
    scalar_job = j;
  endfunction

endpackage
`default_nettype wire

// ===== sv/u2u_front.sv =====
`default_nettype none
module u2u_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [15:0]           code_unit,
  input  wire logic                  string_end,
  output logic                       push,
  output u2u_pkg::job_t              push_job,
  input  wire logic                  full,
  output u2u_pkg::front_status_t     status
);
  import u2u_pkg::*;

  logic       high_pending, high_pending_next;
  logic [9:0] high_bits, high_bits_next;
  logic       discarding, discarding_next;
  logic       accept, is_high, is_low;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign is_high  = code_unit[15:10] == HIGH_SURR_TAG;
  assign is_low   = code_unit[15:10] == LOW_SURR_TAG;
  assign status.pending    = high_pending;
  assign status.discarding = discarding;

  always_comb begin
    high_pending_next = high_pending;
    high_bits_next    = high_bits;
    discarding_next   = discarding;
    push              = 1'b0;
    push_job          = scalar_job({5'd0, code_unit}, string_end);
    if (accept) begin
      if (discarding) begin
        if (string_end) begin
          discarding_next = 1'b0;
        end
      end else if (high_pending) begin
        high_pending_next = 1'b0;
        high_bits_next    = '0;
        push              = 1'b1;
        if (!is_low) begin
          push_job        = error_job();
          discarding_next = !string_end;
        end else begin
          push_job = scalar_job({11'(high_bits) + PLANE_OFFSET, code_unit[9:0]},
                                string_end);
        end
      end else if (is_low) begin
        push            = 1'b1;
        push_job        = error_job();
        discarding_next = !string_end;
      end else if (is_high) begin
        if (string_end) begin
          push     = 1'b1;
          push_job = error_job();
        end else begin
          high_pending_next = 1'b1;
          high_bits_next    = code_unit[9:0];
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
      discarding   <= 1'b0;
    end else begin
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
      discarding   <= discarding_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/u2u_queue.sv =====
`default_nettype none
module u2u_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire u2u_pkg::job_t  push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output u2u_pkg::job_t       head
);
  import u2u_pkg::*;

  localparam int PtrW   = $clog2(DEPTH);
  localparam int CountW = $clog2(DEPTH + 1);

  job_t              entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CountW-1:0] count;
  logic              do_push, do_pop;

  assign full       = count == CountW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/u2u_back.sv =====
`default_nettype none
module u2u_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire u2u_pkg::job_t  head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                string_done,
  output logic                error
);
  import u2u_pkg::*;

  logic [1:0] idx;
  logic       load, at_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign at_last = idx == head.last_idx;
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? 2'd0 : idx + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.bytes[idx];
      run_last    <= at_last;
      string_done <= at_last && head.done;
      error       <= head.err;
    end
  end

endmodule
`default_nettype wire

// ===== sv/utf16_to_utf8_transcoder_unit.sv =====
// UTF-16 to UTF-8 transcoder.
// The input stream carries one UTF-16 code unit per beat on s_axis_tdata, with
// s_axis_tlast marking the last unit of a string. The output stream carries one
// UTF-8 byte per beat; m_axis_tlast marks the byte that ends the string, and
// m_axis_tuser flags the last byte of a unit and an unpaired-surrogate error.
// A classifier takes one unit per cycle while the queue is not full, tracks a
// held high surrogate and the dropping of an aborted string, and writes a byte
// job into a small queue. A serializer drains the queue into an output register
// one byte per cycle while the receiver is ready. The first byte of a unit is
// written into a queue entry and then into the output register.
// Input and output overlap; a unit yields one to four bytes, and the byte-wide
// output register sets the pace. A held high surrogate and dropped units yield
// none.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and s_axis_tready falls once QUEUE_DEPTH jobs wait.
// Reset clears the surrogate state, the queue and the output valid.
`default_nettype none
`include "utf16_to_utf8_transcoder_unit_defines.svh"
module utf16_to_utf8_transcoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] code_unit
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,  // [0] run_last, [1] error
  output logic             m_axis_tlast
);
  import u2u_pkg::*;

  logic          push, full, pop, head_valid;
  job_t          push_job, head;
  front_status_t status;

  u2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .code_unit  (s_axis_tdata),
    .string_end (s_axis_tlast),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .status     (status)
  );

  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  u2u_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .run_last    (m_axis_tuser[0]),
    .string_done (m_axis_tlast),
    .error       (m_axis_tuser[1])
  );

  `U2U_ASSERT_IMP(a_error_beat_ends_run, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0] && m_axis_tdata == 8'd0)
  `U2U_ASSERT_IMP(a_done_is_run_last, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
  `U2U_ASSERT_IMP(a_state_exclusive, clk, rst, 1'b1, !(status.pending && status.discarding))
  `U2U_ASSERT_NEXT(a_high_held, clk, rst, s_axis_tvalid && s_axis_tready && !status.pending && !status.discarding && s_axis_tdata[15:10] == HIGH_SURR_TAG && !s_axis_tlast, status.pending)

endmodule
`default_nettype wire
